@@ rtl/core/qau_pkg.sv @@
`timescale 1ns / 1ps
// qau_pkg: types, constants and helpers for the quaternion arithmetic unit
// no dependencies

package qau_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_W     = 32;
  localparam int DIV_W      = WORD_W + 2 * FRAC_BITS;
  localparam int SQRT_STEPS = 32;

  // pipeline stage indices
  localparam int IDX_IN   = 0;
  localparam int IDX_SQ   = 1;
  localparam int IDX_N2   = 2;
  localparam int IDX_SQ0  = 3;
  localparam int IDX_PREP = IDX_SQ0 + SQRT_STEPS;
  localparam int IDX_DV0  = IDX_PREP + 1;
  localparam int IDX_INV  = IDX_DV0 + DIV_W;
  localparam int IDX_H1M  = IDX_INV + 1;
  localparam int IDX_H1S  = IDX_H1M + 1;
  localparam int IDX_H2M  = IDX_H1S + 1;
  localparam int IDX_H2S  = IDX_H2M + 1;
  localparam int NST      = IDX_H2S + 1;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [2*WORD_W-1:0] prod_t;
  typedef logic signed [2*WORD_W+1:0] acc_t;

  typedef struct packed {
    word_t s;
    word_t x;
    word_t y;
    word_t z;
  } quat_t;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_INV  = 2'd1,
    OP_NORM = 2'd2,
    OP_ROT  = 2'd3
  } op_t;

  typedef struct packed {
    op_t   op;
    quat_t a;
    quat_t b;
  } item_t;

  typedef struct packed {
    logic mul;
    logic sum;
  } ham_en_t;

  typedef struct packed {
    word_t val;
    logic  sat;
  } sat_word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam acc_t  ACC_MAX  = {{(WORD_W+3){1'b0}}, {(WORD_W-1){1'b1}}};
  localparam acc_t  ACC_MIN  = {{(WORD_W+3){1'b1}}, {(WORD_W-1){1'b0}}};

  // fixed-point product, floor rounding
  function automatic prod_t fx_mul(input word_t x, input word_t y);
    prod_t p;
    begin
      p = prod_t'(x) * prod_t'(y);
      return p >>> FRAC_BITS;
    end
  endfunction

  function automatic sat_word_t sat32(input acc_t v);
    sat_word_t r;
    begin
      if (v > ACC_MAX) begin
        r.val = WORD_MAX;
        r.sat = 1'b1;
      end else if (v < ACC_MIN) begin
        r.val = WORD_MIN;
        r.sat = 1'b1;
      end else begin
        r.val = v[WORD_W-1:0];
        r.sat = 1'b0;
      end
      return r;
    end
  endfunction

endpackage

@@ rtl/core/qau_if.sv @@
`timescale 1ns / 1ps
// qau_in_if and qau_out_if: valid/ready channels of the quaternion unit
// depends on nothing; its field widths are written out to match qau_pkg

interface qau_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] a_s;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_s;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  modport source (output valid, op, a_s, a_x, a_y, a_z, b_s, b_x, b_y, b_z, input ready);
  modport sink (input valid, op, a_s, a_x, a_y, a_z, b_s, b_x, b_y, b_z, output ready);
endinterface

interface qau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r_s;
  logic signed [31:0] r_x;
  logic signed [31:0] r_y;
  logic signed [31:0] r_z;
  logic               degenerate;
  logic               saturated;
  modport source (output valid, r_s, r_x, r_y, r_z, degenerate, saturated, input ready);
  modport sink (input valid, r_s, r_x, r_y, r_z, degenerate, saturated, output ready);
endinterface

@@ rtl/core/quaternion_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// quaternion_arithmetic_unit: Q16.16 multiply, inverse, normalize and rotate
// depends on qau_pkg, qau_in_if, qau_out_if and qau_hamilton

// One beat in, one beat out, a new beat every cycle unless the output stalls
// with every stage full. Every operation runs the same 105-stage pipeline,
// so results leave in input order. The depth is set by the restoring square
// root (32 stages, one result bit each) and the four parallel restoring
// dividers (64 stages, one quotient bit each), followed by two Hamilton
// product units of two stages each. Stages collapse bubbles: a stalled output
// holds only the stages behind it that are full, and the input stays ready
// while any stage ahead is empty. The threshold register is written through
// wr_en/wr_data and must change only while the pipeline is empty.

module quaternion_arithmetic_unit import qau_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [15:0]      wr_data,
  qau_in_if.sink           req,
  qau_out_if.source        rsp
);

  // degenerate length threshold
  logic [15:0] thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= 16'd1;
    end else if (wr_en) begin
      thr <= wr_data;
    end
  end

  // stage valids and advance enables
  logic [NST-1:0] v;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v[NST-1] || rsp.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= req.valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  assign req.ready = en[0];
  assign rsp.valid = v[NST-1];

  // operands travel with their beat up to the first product
  item_t it [IDX_INV+1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      it[0].op  <= op_t'(req.op);
      it[0].a.s <= req.a_s;
      it[0].a.x <= req.a_x;
      it[0].a.y <= req.a_y;
      it[0].a.z <= req.a_z;
      it[0].b.s <= req.b_s;
      it[0].b.x <= req.b_x;
      it[0].b.y <= req.b_y;
      it[0].b.z <= req.b_z;
    end
    for (int i = 1; i <= IDX_INV; i++) begin
      if (en[i]) it[i] <= it[i-1];
    end
  end

  // squared length of a
  logic [63:0] sq [4];
  logic [63:0] n2;
  logic [65:0] n2_sum;

  always_ff @(posedge clk) begin
    if (en[IDX_SQ]) begin
      sq[0] <= 64'(prod_t'(it[0].a.s) * prod_t'(it[0].a.s));
      sq[1] <= 64'(prod_t'(it[0].a.x) * prod_t'(it[0].a.x));
      sq[2] <= 64'(prod_t'(it[0].a.y) * prod_t'(it[0].a.y));
      sq[3] <= 64'(prod_t'(it[0].a.z) * prod_t'(it[0].a.z));
    end
  end

  assign n2_sum = 66'(sq[0]) + 66'(sq[1]) + 66'(sq[2]) + 66'(sq[3]);

  // all four at the minimum reaches 2^64 and clamps
  always_ff @(posedge clk) begin
    if (en[IDX_N2]) begin
      n2 <= (n2_sum[65:64] != 2'b00) ? {64{1'b1}} : n2_sum[63:0];
    end
  end

  // restoring square root, one bit a stage
  logic [63:0] sr_r  [SQRT_STEPS];
  logic [63:0] sr_n  [SQRT_STEPS];
  logic [63:0] sr_n2 [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * j);
    logic [63:0] r_in, n_in, n2_in, trial;
    if (j == 0) begin : g_first
      assign r_in  = '0;
      assign n_in  = n2;
      assign n2_in = n2;
    end else begin : g_next
      assign r_in  = sr_r[j-1];
      assign n_in  = sr_n[j-1];
      assign n2_in = sr_n2[j-1];
    end
    assign trial = r_in + BITV;
    always_ff @(posedge clk) begin
      if (en[IDX_SQ0+j]) begin
        sr_n2[j] <= n2_in;
        if (n_in >= trial) begin
          sr_n[j] <= n_in - trial;
          sr_r[j] <= (r_in >> 1) + BITV;
        end else begin
          sr_n[j] <= n_in;
          sr_r[j] <= r_in >> 1;
        end
      end
    end
  end

  // divider setup: divisor, signs and scaled magnitudes
  logic [63:0]      pr_d;
  logic             pr_deg;
  logic [3:0]       pr_neg;
  logic [DIV_W-1:0] pr_num [4];
  word_t            pa [4];

  assign pa[0] = it[IDX_PREP-1].a.s;
  assign pa[1] = it[IDX_PREP-1].a.x;
  assign pa[2] = it[IDX_PREP-1].a.y;
  assign pa[3] = it[IDX_PREP-1].a.z;

  always_ff @(posedge clk) begin
    if (en[IDX_PREP]) begin
      pr_deg <= sr_r[SQRT_STEPS-1] <= 64'(thr);
      pr_d   <= (it[IDX_PREP-1].op == OP_NORM) ? sr_r[SQRT_STEPS-1] : sr_n2[SQRT_STEPS-1];
      for (int k = 0; k < 4; k++) begin
        // inverse conjugates the vector part
        pr_neg[k] <= pa[k][WORD_W-1] ^ ((it[IDX_PREP-1].op != OP_NORM) && (k != 0));
        // magnitude is zero-extended so the minimum word gives 2^31
        if (it[IDX_PREP-1].op == OP_NORM) begin
          pr_num[k] <= DIV_W'($unsigned(pa[k][WORD_W-1] ? -pa[k] : pa[k])) << FRAC_BITS;
        end else begin
          pr_num[k] <= DIV_W'($unsigned(pa[k][WORD_W-1] ? -pa[k] : pa[k]))
                       << (2 * FRAC_BITS);
        end
      end
    end
  end

  // four restoring dividers, one quotient bit a stage
  logic [63:0]      dv_d   [DIV_W];
  logic             dv_deg [DIV_W];
  logic [3:0]       dv_neg [DIV_W];
  logic [63:0]      dv_rem [DIV_W][4];
  logic [DIV_W-1:0] dv_num [DIV_W][4];
  logic [DIV_W-1:0] dv_q   [DIV_W][4];

  for (genvar t = 0; t < DIV_W; t++) begin : g_div
    logic [63:0] d_in;
    logic        dg_in;
    logic [3:0]  ng_in;
    if (t == 0) begin : g_first
      assign d_in  = pr_d;
      assign dg_in = pr_deg;
      assign ng_in = pr_neg;
    end else begin : g_next
      assign d_in  = dv_d[t-1];
      assign dg_in = dv_deg[t-1];
      assign ng_in = dv_neg[t-1];
    end
    always_ff @(posedge clk) begin
      if (en[IDX_DV0+t]) begin
        dv_d[t]   <= d_in;
        dv_deg[t] <= dg_in;
        dv_neg[t] <= ng_in;
      end
    end
    for (genvar k = 0; k < 4; k++) begin : g_lane
      logic [63:0]      rem_in;
      logic [DIV_W-1:0] num_in, q_in;
      logic [64:0]      rem2;
      logic             take;
      if (t == 0) begin : g_first
        assign rem_in = '0;
        assign num_in = pr_num[k];
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = dv_rem[t-1][k];
        assign num_in = dv_num[t-1][k];
        assign q_in   = dv_q[t-1][k];
      end
      assign rem2 = {rem_in, num_in[DIV_W-1]};
      assign take = rem2 >= {1'b0, d_in};
      always_ff @(posedge clk) begin
        if (en[IDX_DV0+t]) begin
          dv_rem[t][k] <= take ? 64'(rem2 - {1'b0, d_in}) : rem2[63:0];
          dv_q[t][k]   <= {q_in[DIV_W-2:0], take};
          dv_num[t][k] <= num_in << 1;
        end
      end
    end
  end

  // sign, clamp and the degenerate bypass
  quat_t iv_inv;
  logic  iv_deg;
  logic  iv_dsat;
  word_t qv [4];
  logic  qs [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (dv_neg[DIV_W-1][k]) begin
        qs[k] = dv_q[DIV_W-1][k] > DIV_W'(64'd1 << (WORD_W - 1));
        qv[k] = qs[k] ? WORD_MIN : -word_t'(dv_q[DIV_W-1][k][WORD_W-1:0]);
      end else begin
        qs[k] = dv_q[DIV_W-1][k] > DIV_W'(WORD_MAX);
        qv[k] = qs[k] ? WORD_MAX : word_t'(dv_q[DIV_W-1][k][WORD_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[IDX_INV]) begin
      iv_deg  <= dv_deg[DIV_W-1];
      iv_dsat <= !dv_deg[DIV_W-1] && (qs[0] || qs[1] || qs[2] || qs[3]);
      if (dv_deg[DIV_W-1]) begin
        iv_inv <= it[IDX_INV-1].a;
      end else begin
        iv_inv <= {qv[0], qv[1], qv[2], qv[3]};
      end
    end
  end

  // first product: a*b, or a*v for rotate
  quat_t h1_b;
  quat_t h1_r;
  logic  h1_sat;

  always_comb begin
    h1_b = it[IDX_INV].b;
    if (it[IDX_INV].op == OP_ROT) h1_b.s = '0;
  end

  qau_hamilton u_h1 (
    .clk (clk),
    .en  ('{mul: en[IDX_H1M], sum: en[IDX_H1S]}),
    .a   (it[IDX_INV].a),
    .b   (h1_b),
    .r   (h1_r),
    .sat (h1_sat)
  );

  op_t   s1_op   [2];
  logic  s1_deg  [2];
  logic  s1_dsat [2];
  quat_t s1_inv  [2];

  always_ff @(posedge clk) begin
    if (en[IDX_H1M]) begin
      s1_op[0]   <= it[IDX_INV].op;
      s1_deg[0]  <= iv_deg;
      s1_dsat[0] <= iv_dsat;
      s1_inv[0]  <= iv_inv;
    end
    if (en[IDX_H1S]) begin
      s1_op[1]   <= s1_op[0];
      s1_deg[1]  <= s1_deg[0];
      s1_dsat[1] <= s1_dsat[0];
      s1_inv[1]  <= s1_inv[0];
    end
  end

  // second product: (a*v) * inverse(a)
  quat_t h2_r;
  logic  h2_sat;

  qau_hamilton u_h2 (
    .clk (clk),
    .en  ('{mul: en[IDX_H2M], sum: en[IDX_H2S]}),
    .a   (h1_r),
    .b   (s1_inv[1]),
    .r   (h2_r),
    .sat (h2_sat)
  );

  op_t   s2_op    [2];
  logic  s2_deg   [2];
  logic  s2_dsat  [2];
  quat_t s2_inv   [2];
  quat_t s2_h1    [2];
  logic  s2_h1sat [2];

  always_ff @(posedge clk) begin
    if (en[IDX_H2M]) begin
      s2_op[0]    <= s1_op[1];
      s2_deg[0]   <= s1_deg[1];
      s2_dsat[0]  <= s1_dsat[1];
      s2_inv[0]   <= s1_inv[1];
      s2_h1[0]    <= h1_r;
      s2_h1sat[0] <= h1_sat;
    end
    if (en[IDX_H2S]) begin
      s2_op[1]    <= s2_op[0];
      s2_deg[1]   <= s2_deg[0];
      s2_dsat[1]  <= s2_dsat[0];
      s2_inv[1]   <= s2_inv[0];
      s2_h1[1]    <= s2_h1[0];
      s2_h1sat[1] <= s2_h1sat[0];
    end
  end

  // result select
  always_comb begin
    case (s2_op[1])
      OP_MUL: begin
        {rsp.r_s, rsp.r_x, rsp.r_y, rsp.r_z} = s2_h1[1];
        rsp.degenerate = 1'b0;
        rsp.saturated  = s2_h1sat[1];
      end
      OP_INV, OP_NORM: begin
        {rsp.r_s, rsp.r_x, rsp.r_y, rsp.r_z} = s2_inv[1];
        rsp.degenerate = s2_deg[1];
        rsp.saturated  = s2_dsat[1];
      end
      OP_ROT: begin
        rsp.r_s = '0;
        rsp.r_x = h2_r.x;
        rsp.r_y = h2_r.y;
        rsp.r_z = h2_r.z;
        rsp.degenerate = s2_deg[1];
        rsp.saturated  = s2_dsat[1] | s2_h1sat[1] | h2_sat;
      end
      default: begin
        {rsp.r_s, rsp.r_x, rsp.r_y, rsp.r_z} = s2_h1[1];
        rsp.degenerate = 1'b0;
        rsp.saturated  = s2_h1sat[1];
      end
    endcase
  end

  // input stalls only when every stage is full and the output is held
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> ((&v) && !rsp.ready))
    else $error("input stalled with an empty stage");

  // a degenerate a bypasses the divider, which then cannot clamp
  a_deg_no_dsat: assert property (@(posedge clk) disable iff (rst)
    (v[NST-1] && s2_deg[1]) |-> !s2_dsat[1])
    else $error("divider clamp on a degenerate beat");

  // a beat moving into the last stage is not dropped
  a_last_move: assert property (@(posedge clk) disable iff (rst)
    (v[NST-2] && en[NST-1]) |=> v[NST-1])
    else $error("beat lost entering the output stage");

endmodule

@@ rtl/core/qau_hamilton.sv @@
`timescale 1ns / 1ps
// qau_hamilton: two-stage saturating fixed-point Hamilton product
// depends on qau_pkg

module qau_hamilton import qau_pkg::*; (
  input  logic    clk,
  input  ham_en_t en,
  input  quat_t   a,
  input  quat_t   b,
  output quat_t   r,
  output logic    sat
);

  prod_t p [16];

  // stage 1: sixteen products
  always_ff @(posedge clk) begin
    if (en.mul) begin
      p[0]  <= fx_mul(a.s, b.s);
      p[1]  <= fx_mul(a.x, b.x);
      p[2]  <= fx_mul(a.y, b.y);
      p[3]  <= fx_mul(a.z, b.z);
      p[4]  <= fx_mul(a.s, b.x);
      p[5]  <= fx_mul(b.s, a.x);
      p[6]  <= fx_mul(a.y, b.z);
      p[7]  <= fx_mul(a.z, b.y);
      p[8]  <= fx_mul(a.s, b.y);
      p[9]  <= fx_mul(b.s, a.y);
      p[10] <= fx_mul(a.z, b.x);
      p[11] <= fx_mul(a.x, b.z);
      p[12] <= fx_mul(a.s, b.z);
      p[13] <= fx_mul(b.s, a.z);
      p[14] <= fx_mul(a.x, b.y);
      p[15] <= fx_mul(a.y, b.x);
    end
  end

  sat_word_t rs, rx, ry, rz;

  always_comb begin
    rs = sat32(acc_t'(p[0]) - acc_t'(p[1]) - acc_t'(p[2]) - acc_t'(p[3]));
    rx = sat32(acc_t'(p[4]) + acc_t'(p[5]) + acc_t'(p[6]) - acc_t'(p[7]));
    ry = sat32(acc_t'(p[8]) + acc_t'(p[9]) + acc_t'(p[10]) - acc_t'(p[11]));
    rz = sat32(acc_t'(p[12]) + acc_t'(p[13]) + acc_t'(p[14]) - acc_t'(p[15]));
  end

  // stage 2: sums and clamp
  always_ff @(posedge clk) begin
    if (en.sum) begin
      r.s <= rs.val;
      r.x <= rx.val;
      r.y <= ry.val;
      r.z <= rz.val;
      sat <= rs.sat | rx.sat | ry.sat | rz.sat;
    end
  end

endmodule
